FILE: sv/rpt_pkg.sv
// rpt_pkg: shared types and constants of the rtd pid tec controller
// no dependencies; every other file of the block imports it
`default_nettype none

package rpt_pkg;

   // field widths
   localparam int TEMP_W   = 17;
   localparam int GAIN_W   = 16;
   localparam int DUTY_W   = 16;
   localparam int INTEG_W  = 13;
   localparam int MAG_W    = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD  = 3'd4;

   // register reset values
   localparam logic signed [TEMP_W-1:0] TARGET_RESET = 17'sd2500;
   localparam logic [GAIN_W-1:0]        GAIN_P_RESET = 16'd256;
   localparam logic [GAIN_W-1:0]        GAIN_I_RESET = 16'd0;
   localparam logic [GAIN_W-1:0]        GAIN_D_RESET = 16'd0;
   localparam logic [DUTY_W-1:0]        PERIOD_RESET = 16'd65535;

   localparam logic signed [TEMP_W-1:0] TARGET_MIN = -17'sd50000;
   localparam logic signed [TEMP_W-1:0] TARGET_MAX = 17'sd50000;

   // serial unit widths
   localparam int MUL_MC_W = 40;
   localparam int MUL_MP_W = 32;
   localparam int MUL_P_W  = 64;
   localparam int RAD_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int DIV_N_W  = 46;
   localparam int DIV_D_W  = 29;
   localparam int DIV_Q_W  = 16;
   localparam int DRIVE_ACC_W = 40;
   localparam int DRIVE_W     = 22;

   // callendar-van dusen inversion, scaled by 2^32 under the root
   localparam logic [RAD_W-1:0]    SQRT_BASE     = 64'd1527480889 << 32;
   localparam logic [27:0]         CVD_K         = 28'd231000000;
   localparam logic [ROOT_W-1:0]   ROOT_ZERO     = 32'd2561343488;
   localparam logic [15:0]         T_SCALE       = 16'd50000;
   localparam logic [DIV_D_W-1:0]  DIV_TEMP      = 29'd378470400;
   localparam logic [DIV_D_W-1:0]  DIV_TEMP_HALF = 29'd189235200;
   localparam logic [DIV_Q_W-1:0]  COLD_LIMIT    = 16'd10000;

   // pid constants
   localparam logic [DIV_D_W-1:0]  DIV_TEN    = 29'd10;
   localparam logic [MAG_W-1:0]    INC_ROUND  = 17'd5;
   localparam logic [INTEG_W-1:0]  INTEG_MAX  = 13'd5000;
   localparam logic [DRIVE_W-1:0]  DRIVE_FULL = 22'd2560000;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_D,
      ST_SQRT,
      ST_MUL_T,
      ST_DIV_T,
      ST_DIV_I,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_K,
      ST_CLAMP,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_OUT
   } ctl_state_type;

   // requests to the serial units
   typedef struct packed {
      logic                       start;
      logic signed [MUL_MC_W-1:0] mcand;
      logic [MUL_MP_W-1:0]        mplier;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

FILE: sv/rpt_channels.sv
// rpt channel interfaces: adc request, controller response, register write
// depends on rpt_pkg for field widths
`default_nettype none

interface rpt_req_if #(parameter int ADC_WIDTH = 24);
   logic                        valid;
   logic                        ready;
   logic signed [ADC_WIDTH-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface rpt_rsp_if
   import rpt_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] measured_temp;
   logic                     sensor_error;
   logic [DUTY_W-1:0]        duty_count;
   logic                     heating;

   modport source (output valid, output measured_temp, output sensor_error,
                   output duty_count, output heating, input ready);
   modport sink   (input valid, input measured_temp, input sensor_error,
                   input duty_count, input heating, output ready);
endinterface

interface rpt_csr_if
   import rpt_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  wr_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: sv/rpt_serial_mul.sv
// rpt_serial_mul: shift-and-add multiplier, one multiplier bit per cycle
// depends on rpt_pkg (mul_req_type, widths)
`default_nettype none

module rpt_serial_mul
   import rpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mul_req_type               req,
   output logic                      done,
   output logic signed [MUL_P_W-1:0] product
);

   logic                      busy_ff;
   logic                      done_ff;
   logic signed [MUL_P_W-1:0] acc_ff;
   logic signed [MUL_P_W-1:0] mc_ff;
   logic [MUL_MP_W-1:0]       mp_ff;
   logic                      last_step;

   // finish on the step that consumes the top set bit
   assign last_step = (mp_ff[MUL_MP_W-1:1] == '0);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && last_step) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   // accumulate shifted multiplicand under each set bit
   always_ff @(posedge clock) begin
      if (req.start) begin
         acc_ff <= '0;
         mc_ff  <= MUL_P_W'(req.mcand);
         mp_ff  <= req.mplier;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= mc_ff <<< 1;
         mp_ff <= mp_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

FILE: sv/rpt_serial_sqrt.sv
// rpt_serial_sqrt: restoring integer square root, one root bit per cycle
// depends on rpt_pkg (sqrt_req_type, widths)
`default_nettype none

module rpt_serial_sqrt
   import rpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sqrt_req_type      req,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(ROOT_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RAD_W-1:0]  x_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W+1:0]  rem_shift;
   logic [REM_W+1:0]  trial;
   logic              fits;

   // bring down the next two radicand bits and try root*4+1
   assign rem_shift = {rem_ff, x_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // one root bit per step
   always_ff @(posedge clock) begin
      if (req.start) begin
         x_ff    <= req.radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= x_ff << 2;
         rem_ff  <= fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

FILE: sv/rpt_serial_div.sv
// rpt_serial_div: restoring divider, one quotient bit per cycle
// depends on rpt_pkg (div_req_type, widths)
`default_nettype none

module rpt_serial_div
   import rpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic [DIV_Q_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_Q_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIV_N_W-1:0] rem_ff;
   logic [DIV_N_W-1:0] dsh_ff;
   logic [DIV_Q_W-1:0] quot_ff;
   logic               fits;

   assign fits = (rem_ff >= dsh_ff);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_Q_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // divisor walks down from its top quotient position
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= req.num;
         dsh_ff  <= DIV_N_W'(req.divisor) << (DIV_Q_W - 1);
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[DIV_Q_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: sv/rtd_pid_tec_controller.sv
// rtd_pid_tec_controller: rtd code to temperature, pid drive to pwm count
// depends on rpt_pkg, rpt_channels, rpt_serial_mul, rpt_serial_sqrt, rpt_serial_div
//
// channel   direction  word
// req_ch    in         adc_code
// rsp_ch    out        measured_temp, sensor_error, duty_count, heating
// csr_ch    in         wr_index, wr_data (register write, always ready)
//
// one word at a time; a word with a sensor error skips the pid steps. the
// 32-step square root and the shared one bit per cycle multiplier (six
// products) and divider (three quotients) set the time a word takes.
// synchronous active-high reset clears sequencer, registers and pid state.
// a result held by a stalled rsp_ch does not stop the next word from being
// taken and worked; only its delivery waits for the output register.
`default_nettype none

module rtd_pid_tec_controller
   import rpt_pkg::*;
#(
   parameter int ADC_WIDTH = 24
)(
   input  logic         clock,
   input  logic         reset,
   rpt_req_if.sink      req_ch,
   rpt_rsp_if.source    rsp_ch,
   rpt_csr_if.sink      csr_ch
);

   localparam int D_W       = ADC_WIDTH + 1;
   localparam int RAD_SHIFT = ROOT_W + 1 - ADC_WIDTH;

   ctl_state_type state_ff, state_in;

   // configuration and loop state
   logic signed [TEMP_W-1:0] target_ff;
   logic [GAIN_W-1:0]        kp_ff, ki_ff, kd_ff;
   logic [DUTY_W-1:0]        period_ff;
   logic [INTEG_W-1:0]       integ_ff;
   logic [MAG_W-1:0]         prev_ff;
   logic [DUTY_W-1:0]        last_duty_ff;
   logic                     last_heating_ff;

   // per-word work registers
   logic [DIV_Q_W-1:0]            q_ff;
   logic                          bad_ff;
   logic [MAG_W-1:0]              mag_ff;
   logic                          dir_ff;
   logic [INTEG_W-1:0]            integ_new_ff;
   logic signed [DRIVE_ACC_W-1:0] drive_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic                     rsp_err_ff;
   logic [DUTY_W-1:0]        rsp_duty_ff;
   logic                     rsp_heat_ff;

   // unit connections
   mul_req_type               mul_req;
   sqrt_req_type              sqrt_req;
   div_req_type               div_req;
   logic                      mul_done, sqrt_done, div_done;
   logic signed [MUL_P_W-1:0] mul_product;
   logic [ROOT_W-1:0]         sqrt_root;
   logic [DIV_Q_W-1:0]        div_quot;

   // combinational helpers
   logic                     req_fire, csr_fire, load_out, commit;
   logic signed [TEMP_W-1:0] csr_target;
   logic                     csr_target_ok;
   logic [D_W-1:0]           d_now;
   logic [ROOT_W-1:0]        root_excess;
   logic                     cold_now;
   logic signed [TEMP_W:0]   diff_now;
   logic                     dir_now;
   logic [MAG_W-1:0]         mag_now;
   logic [INTEG_W:0]         integ_sum;
   logic [INTEG_W-1:0]       integ_clamped;
   logic signed [MAG_W:0]    delta;
   logic signed [DRIVE_W-1:0] delta10;
   logic [DRIVE_W-1:0]       drive_clamped;

   rpt_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   rpt_serial_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   rpt_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // handshakes
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign load_out     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign commit       = (state_ff == ST_DIV_Y) && div_done;

   // setpoint write range check
   assign csr_target    = signed'(csr_ch.wr_data);
   assign csr_target_ok = (csr_target >= TARGET_MIN) && (csr_target <= TARGET_MAX);

   // ratio distance below full scale: half - code, always 1..2^W
   assign d_now = (D_W'(1) << (ADC_WIDTH - 1)) - D_W'(req_ch.adc_code);

   // root never falls below the 0 C point, so the excess is nonnegative
   assign root_excess = sqrt_root - ROOT_ZERO;

   // temperature is minus the quotient; error and magnitude from it
   assign cold_now = (div_quot > COLD_LIMIT);
   assign diff_now = (TEMP_W + 1)'(target_ff) + signed'((TEMP_W + 1)'(div_quot));
   assign dir_now  = !diff_now[TEMP_W] && (diff_now != '0);
   assign mag_now  = diff_now[TEMP_W] ? MAG_W'(-diff_now) : MAG_W'(diff_now);

   // integral update with saturation
   assign integ_sum     = (INTEG_W + 1)'(integ_ff) + (INTEG_W + 1)'(div_quot);
   assign integ_clamped = (integ_sum > (INTEG_W + 1)'(INTEG_MAX)) ?
                          INTEG_MAX : INTEG_W'(integ_sum);

   // derivative term operand, ten times the change of the error magnitude
   assign delta   = signed'((MAG_W + 1)'(mag_ff)) - signed'((MAG_W + 1)'(prev_ff));
   assign delta10 = (DRIVE_W'(delta) <<< 3) + (DRIVE_W'(delta) <<< 1);

   // drive clamp to 0..full scale
   always_comb begin
      if (drive_ff[DRIVE_ACC_W-1]) begin
         drive_clamped = '0;
      end else if (drive_ff > DRIVE_ACC_W'(DRIVE_FULL)) begin
         drive_clamped = DRIVE_FULL;
      end else begin
         drive_clamped = DRIVE_W'(drive_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire)  state_in = ST_MUL_D;
         ST_MUL_D: if (mul_done)  state_in = ST_SQRT;
         ST_SQRT:  if (sqrt_done) state_in = ST_MUL_T;
         ST_MUL_T: if (mul_done)  state_in = ST_DIV_T;
         ST_DIV_T: if (div_done)  state_in = cold_now ? ST_OUT : ST_DIV_I;
         ST_DIV_I: if (div_done)  state_in = ST_MUL_P;
         ST_MUL_P: if (mul_done)  state_in = ST_MUL_I;
         ST_MUL_I: if (mul_done)  state_in = ST_MUL_K;
         ST_MUL_K: if (mul_done)  state_in = ST_CLAMP;
         ST_CLAMP:                state_in = ST_MUL_Y;
         ST_MUL_Y: if (mul_done)  state_in = ST_DIV_Y;
         ST_DIV_Y: if (div_done)  state_in = ST_OUT;
         ST_OUT:   if (load_out)  state_in = ST_IDLE;
         default:                 state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // unit launches and operands
   always_comb begin
      mul_req  = '0;
      sqrt_req = '0;
      div_req  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            mul_req.start  = req_fire;
            mul_req.mcand  = MUL_MC_W'(d_now);
            mul_req.mplier = MUL_MP_W'(CVD_K);
         end
         ST_MUL_D: begin
            sqrt_req.start    = mul_done;
            sqrt_req.radicand = SQRT_BASE + (unsigned'(mul_product) << RAD_SHIFT);
         end
         ST_SQRT: begin
            mul_req.start  = sqrt_done;
            mul_req.mcand  = MUL_MC_W'(root_excess);
            mul_req.mplier = MUL_MP_W'(T_SCALE);
         end
         ST_MUL_T: begin
            div_req.start   = mul_done;
            div_req.num     = DIV_N_W'(unsigned'(mul_product)) + DIV_N_W'(DIV_TEMP_HALF);
            div_req.divisor = DIV_TEMP;
         end
         ST_DIV_T: begin
            div_req.start   = div_done && !cold_now;
            div_req.num     = DIV_N_W'(mag_now) + DIV_N_W'(INC_ROUND);
            div_req.divisor = DIV_TEN;
         end
         ST_DIV_I: begin
            mul_req.start  = div_done;
            mul_req.mcand  = MUL_MC_W'(mag_ff);
            mul_req.mplier = MUL_MP_W'(kp_ff);
         end
         ST_MUL_P: begin
            mul_req.start  = mul_done;
            mul_req.mcand  = MUL_MC_W'(integ_new_ff);
            mul_req.mplier = MUL_MP_W'(ki_ff);
         end
         ST_MUL_I: begin
            mul_req.start  = mul_done;
            mul_req.mcand  = MUL_MC_W'(delta10);
            mul_req.mplier = MUL_MP_W'(kd_ff);
         end
         ST_CLAMP: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = MUL_MC_W'(drive_clamped);
            mul_req.mplier = MUL_MP_W'(period_ff);
         end
         ST_MUL_Y: begin
            div_req.start   = mul_done;
            div_req.num     = DIV_N_W'(unsigned'(mul_product));
            div_req.divisor = DIV_D_W'(DRIVE_FULL);
         end
         ST_MUL_K, ST_DIV_Y, ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // per-word results
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV_T) && div_done) begin
         q_ff   <= div_quot;
         bad_ff <= cold_now;
         mag_ff <= mag_now;
         dir_ff <= dir_now;
      end
      if ((state_ff == ST_DIV_I) && div_done) begin
         integ_new_ff <= integ_clamped;
      end
      if ((state_ff == ST_MUL_P) && mul_done) begin
         drive_ff <= DRIVE_ACC_W'(mul_product);
      end
      if (((state_ff == ST_MUL_I) || (state_ff == ST_MUL_K)) && mul_done) begin
         drive_ff <= drive_ff + DRIVE_ACC_W'(mul_product);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         kp_ff     <= GAIN_P_RESET;
         ki_ff     <= GAIN_I_RESET;
         kd_ff     <= GAIN_D_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_fire) begin
         unique case (csr_ch.wr_index)
            CSR_TARGET_TEMP: if (csr_target_ok) target_ff <= csr_target;
            CSR_GAIN_P:      kp_ff     <= GAIN_W'(csr_ch.wr_data);
            CSR_GAIN_I:      ki_ff     <= GAIN_W'(csr_ch.wr_data);
            CSR_GAIN_D:      kd_ff     <= GAIN_W'(csr_ch.wr_data);
            CSR_PWM_PERIOD:  period_ff <= DUTY_W'(csr_ch.wr_data);
            default: begin
            end
         endcase
      end
   end

   // loop state: an in-range setpoint write clears integral and previous error
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff        <= '0;
         prev_ff         <= '0;
         last_duty_ff    <= '0;
         last_heating_ff <= 1'b0;
      end else if (csr_fire && (csr_ch.wr_index == CSR_TARGET_TEMP) && csr_target_ok) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else if (commit) begin
         integ_ff        <= integ_new_ff;
         prev_ff         <= mag_ff;
         last_duty_ff    <= div_quot;
         last_heating_ff <= dir_ff;
      end
   end

   // output register; error words repeat the last drive
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_temp_ff <= TEMP_W'(0) - signed'(TEMP_W'(q_ff));
         rsp_err_ff  <= bad_ff;
         rsp_duty_ff <= last_duty_ff;
         rsp_heat_ff <= last_heating_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.measured_temp = rsp_temp_ff;
   assign rsp_ch.sensor_error  = rsp_err_ff;
   assign rsp_ch.duty_count    = rsp_duty_ff;
   assign rsp_ch.heating       = rsp_heat_ff;

endmodule

`default_nettype wire

FILE: sv/rpt_checker.sv
// rpt_checker: port-level assertions for the rtd pid tec controller
// depends on rpt_pkg; bound to rtd_pid_tec_controller at the end of this file
`default_nettype none

module rpt_checker
   import rpt_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] rsp_measured_temp,
   input logic                     rsp_sensor_error,
   input logic [DUTY_W-1:0]        rsp_duty_count,
   input logic                     rsp_heating
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_measured_temp, rsp_sensor_error, rsp_duty_count, rsp_heating}))
      else $error("response word changed while stalled");

   // one word in flight: the port closes right after a word is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   // error flag only on a cold reading
   a_cold_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_error |-> rsp_measured_temp < -17'sd10000)
      else $error("sensor error on a usable reading");

   // usable readings lie between the cold limit and zero degrees
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sensor_error |->
         rsp_measured_temp >= -17'sd10000 && rsp_measured_temp <= 17'sd0)
      else $error("usable reading out of range");

endmodule

bind rtd_pid_tec_controller rpt_checker u_rpt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_measured_temp (rsp_ch.measured_temp),
   .rsp_sensor_error  (rsp_ch.sensor_error),
   .rsp_duty_count    (rsp_ch.duty_count),
   .rsp_heating       (rsp_ch.heating)
);

`default_nettype wire
